FILE: rtl/bavg_pkg.sv
// ----------------------------------------------------------------------------
// bavg_pkg
// shared types, constants and reciprocal tables of the block average downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package bavg_pkg;

  localparam int unsigned MAX_LINE_PIXELS = 8192;
  localparam int unsigned BIN_DEPTH       = MAX_LINE_PIXELS / 2;
  localparam int unsigned BIN_AW          = $clog2(BIN_DEPTH);
  localparam int unsigned SUM_W           = 14;
  localparam int unsigned COL_W           = 13;
  localparam int unsigned LINE_W          = 14;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned FACTOR_W        = 4;
  localparam int unsigned RECIP_W         = 19;

  // configuration register indexes
  localparam logic CFG_LINE_PIXELS = 1'b0;
  localparam logic CFG_FACTOR      = 1'b1;

  localparam logic [LINE_W-1:0]   LINE_RESET   = LINE_W'(1024);
  localparam logic [LINE_W-1:0]   LINE_MAX     = LINE_W'(MAX_LINE_PIXELS);
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(1);
  localparam logic [FACTOR_W-1:0] FACTOR_MAX   = FACTOR_W'(8);

  // request toward the line store: one pixel that falls into a whole bin
  typedef struct packed {
    logic [BIN_AW-1:0]   bin;
    logic [PIX_W-1:0]    pixel;
    logic                first;
    logic                emit;
    logic                last;
    logic [FACTOR_W-1:0] factor;
    logic [5:0]          half_sq;
  } bin_req_t;

  // finished block sum on its way to the rounding divider
  typedef struct packed {
    logic [SUM_W-1:0]    sum;
    logic                last;
    logic [FACTOR_W-1:0] factor;
    logic [5:0]          half_sq;
  } blk_sum_t;

  // ceil(2^19 / f), exact quotient for any 14-bit numerator
  function automatic logic [RECIP_W-1:0] recip_factor(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] m;
    unique case (f)
      4'd2:    m = RECIP_W'(262144);
      4'd3:    m = RECIP_W'(174763);
      4'd4:    m = RECIP_W'(131072);
      4'd5:    m = RECIP_W'(104858);
      4'd6:    m = RECIP_W'(87382);
      4'd7:    m = RECIP_W'(74899);
      4'd8:    m = RECIP_W'(65536);
      default: m = '0;
    endcase
    return m;
  endfunction

  // ceil(2^20 / f^2), exact quotient for any 15-bit numerator
  function automatic logic [RECIP_W-1:0] recip_square(input logic [FACTOR_W-1:0] f);
    logic [RECIP_W-1:0] m;
    unique case (f)
      4'd2:    m = RECIP_W'(262144);
      4'd3:    m = RECIP_W'(116509);
      4'd4:    m = RECIP_W'(65536);
      4'd5:    m = RECIP_W'(41944);
      4'd6:    m = RECIP_W'(29128);
      4'd7:    m = RECIP_W'(21400);
      4'd8:    m = RECIP_W'(16384);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bavg_ram.sv
// ----------------------------------------------------------------------------
// bavg_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_ram #(
  parameter int unsigned WIDTH = 14,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bavg_locate.sv
// ----------------------------------------------------------------------------
// bavg_locate
// column and line counters, bin and sub-column split, store read address
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_locate import bavg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                advance_i,
  input  wire logic [PIX_W-1:0]    pixel_i,
  input  wire logic                frame_start_i,
  input  wire logic [LINE_W-1:0]   line_pixels_i,
  input  wire logic [FACTOR_W-1:0] factor_i,
  output logic      [BIN_AW-1:0]   rd_addr_o,
  output logic                     req_valid_o,
  output bin_req_t                 req_o
);

  logic [COL_W-1:0]    column_q, column_d;
  logic [2:0]          lig_q, lig_d;
  logic [COL_W-1:0]    col_cur;
  logic [2:0]          lig_cur;
  logic [FACTOR_W-1:0] f_eff;
  logic [LINE_W-1:0]   lp_eff;
  logic [31:0]         prod_d;

  logic                s1_valid_q;
  logic [31:0]         s1_prod_q;
  logic [COL_W-1:0]    s1_col_q;
  logic [2:0]          s1_lig_q;
  logic [PIX_W-1:0]    s1_pix_q;
  logic [FACTOR_W-1:0] s1_f_q;
  logic [LINE_W-1:0]   s1_lp_q;

  logic [BIN_AW-1:0]   bin;
  logic [15:0]         bin_f_full;
  logic [COL_W-1:0]    bin_f;
  logic [COL_W-1:0]    sub_full;
  logic [2:0]          sub;
  logic [LINE_W:0]     end_one;
  logic [LINE_W:0]     end_two;
  logic                hit;
  logic [FACTOR_W-1:0] f_m1;
  logic [7:0]          sq;
  bin_req_t            req_d;
  logic                req_valid_q;
  bin_req_t            req_q;

  // effective settings
  always_comb begin
    f_eff = (factor_i > FACTOR_MAX) ? FACTOR_MAX : factor_i;
    if (line_pixels_i == '0) begin
      lp_eff = LINE_W'(1);
    end else if (line_pixels_i > LINE_MAX) begin
      lp_eff = LINE_MAX;
    end else begin
      lp_eff = line_pixels_i;
    end
  end

  // counter advance at the accepted pixel
  always_comb begin
    col_cur  = frame_start_i ? '0 : column_q;
    lig_cur  = frame_start_i ? '0 : lig_q;
    prod_d   = 32'(col_cur) * 32'(recip_factor(f_eff));
    column_d = col_cur + COL_W'(1);
    lig_d    = lig_cur;
    if ((LINE_W'(col_cur) + LINE_W'(1)) >= lp_eff) begin
      column_d = '0;
      if (f_eff >= FACTOR_W'(2) && ({1'b0, lig_cur} + FACTOR_W'(1)) < f_eff) begin
        lig_d = lig_cur + 3'd1;
      end else begin
        lig_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q   <= '0;
      lig_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        column_q <= column_d;
        lig_q    <= lig_d;
      end
      if (advance_i) begin
        s1_valid_q <= accept_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_prod_q <= prod_d;
      s1_col_q  <= col_cur;
      s1_lig_q  <= lig_cur;
      s1_pix_q  <= pixel_i;
      s1_f_q    <= f_eff;
      s1_lp_q   <= lp_eff;
    end
  end

  // bin = column / f, sub = column % f
  always_comb begin
    bin        = s1_prod_q[30:19];
    bin_f_full = 16'(bin) * 16'(s1_f_q);
    bin_f      = bin_f_full[COL_W-1:0];
    sub_full   = s1_col_q - bin_f;
    sub        = sub_full[2:0];
    end_one    = (LINE_W+1)'(bin_f) + (LINE_W+1)'(s1_f_q);
    end_two    = end_one + (LINE_W+1)'(s1_f_q);
    hit        = (s1_f_q >= FACTOR_W'(2)) && (end_one <= {1'b0, s1_lp_q});
    f_m1       = s1_f_q - FACTOR_W'(1);
    sq         = 8'(s1_f_q) * 8'(s1_f_q);

    req_d.bin     = bin;
    req_d.pixel   = s1_pix_q;
    req_d.first   = (s1_lig_q == 3'd0) && (sub == 3'd0);
    req_d.emit    = ({1'b0, s1_lig_q} == f_m1) && ({1'b0, sub} == f_m1);
    // partial bin at line end is never hit, so the next whole bin does not fit
    req_d.last    = end_two > {1'b0, s1_lp_q};
    req_d.factor  = s1_f_q;
    req_d.half_sq = sq[6:1];
  end

  assign rd_addr_o = bin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (advance_i) begin
      req_valid_q <= s1_valid_q && hit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      req_q <= req_d;
    end
  end

  assign req_valid_o = req_valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

FILE: rtl/bavg_accum.sv
// ----------------------------------------------------------------------------
// bavg_accum
// line store of bin sums: read, add the pixel, write back with forwarding
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_accum import bavg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire logic [BIN_AW-1:0] rd_addr_i,
  input  wire logic              req_valid_i,
  input  wire bin_req_t          req_i,
  output logic                   sum_valid_o,
  output blk_sum_t               sum_o
);

  logic [SUM_W-1:0]  rd_data;
  logic              fwd_valid_q;
  logic [BIN_AW-1:0] fwd_addr_q;
  logic [SUM_W-1:0]  fwd_data_q;
  logic              fwd_hit;
  logic [SUM_W-1:0]  prev;
  logic [SUM_W-1:0]  sum;
  logic              wr_en;
  logic              sum_valid_q;
  blk_sum_t          sum_q;
  blk_sum_t          sum_d;

  bavg_ram #(
    .WIDTH (SUM_W),
    .DEPTH (BIN_DEPTH)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (req_i.bin),
    .wdata_i (sum),
    .re_i    (advance_i),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  // the write of the previous step lands while this request was read
  assign fwd_hit = fwd_valid_q && (fwd_addr_q == req_i.bin);
  assign prev    = fwd_hit ? fwd_data_q : rd_data;
  assign sum     = req_i.first ? SUM_W'(req_i.pixel) : (prev + SUM_W'(req_i.pixel));
  assign wr_en   = advance_i && req_valid_i;

  always_comb begin
    sum_d.sum     = sum;
    sum_d.last    = req_i.last;
    sum_d.factor  = req_i.factor;
    sum_d.half_sq = req_i.half_sq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else if (advance_i) begin
      fwd_valid_q <= req_valid_i;
      sum_valid_q <= req_valid_i && req_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      fwd_addr_q <= req_i.bin;
      fwd_data_q <= sum;
      sum_q      <= sum_d;
    end
  end

  assign sum_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

`default_nettype wire

FILE: rtl/bavg_round.sv
// ----------------------------------------------------------------------------
// bavg_round
// rounded division of a block sum by factor squared, output register
// ----------------------------------------------------------------------------
`default_nettype none

module bavg_round import bavg_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire logic             sum_valid_i,
  input  wire blk_sum_t         sum_i,
  output logic                  out_valid_o,
  output logic      [PIX_W-1:0] average_o,
  output logic                  line_end_o
);

  logic [SUM_W:0]  num;
  logic [33:0]     prod;
  logic            valid_q;
  logic [PIX_W-1:0] avg_q;
  logic            line_end_q;

  // multiply by reciprocal of f^2, exact for this numerator range
  assign num  = (SUM_W+1)'(sum_i.sum) + (SUM_W+1)'(sum_i.half_sq);
  assign prod = 34'(num) * 34'(recip_square(sum_i.factor));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= sum_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && sum_valid_i) begin
      avg_q      <= prod[27:20];
      line_end_q <= sum_i.last;
    end
  end

  assign out_valid_o = valid_q;
  assign average_o   = avg_q;
  assign line_end_o  = line_end_q;

endmodule

`default_nettype wire

FILE: rtl/block_average_downscaler_unit.sv
// ----------------------------------------------------------------------------
// block_average_downscaler_unit
// shrinks an 8-bit raster image by averaging factor x factor pixel blocks
// ----------------------------------------------------------------------------
// Pixels enter on the input channel (pixel_i, frame_start_i) under
// in_valid_i / in_stall_o; one averaged pixel leaves on the output channel
// (average_o, line_end_o) under out_valid_o / out_stall_i for each block that
// completes on the last line of a line group. frame_start_i restarts the
// column and line-group counters at that pixel.
// One pixel request is taken every clock while the output is not stalled. A
// result is registered through counter and bin split, line store read, sum
// and write-back, and reciprocal divide into the output register. The
// line store read-modify-write forwards the previous write, which holds the
// rate at one pixel per clock while the output is not stalled.
// When the output holds a result and out_stall_i is high, the whole pipeline
// freezes and in_stall_o is raised until the result is taken.
// Reset clears the counters and pipeline and sets line_pixels to 1024 and
// factor to 1. The line store is not cleared: the first line of each group
// writes its bins before they are read.
// Configuration: cfg_we_i writes cfg_data_i to cfg_index_i (line_pixels or
// factor); the user writes only while the block is idle, not enforced here.
// ----------------------------------------------------------------------------
`default_nettype none

module block_average_downscaler_unit import bavg_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [LINE_W-1:0] cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [PIX_W-1:0]  pixel_i,
  input  wire logic              frame_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic      [PIX_W-1:0]  average_o,
  output logic                   line_end_o
);

  logic [LINE_W-1:0]   line_pixels_q;
  logic [FACTOR_W-1:0] factor_q;
  logic                advance;
  logic                accept;
  logic [BIN_AW-1:0]   rd_addr;
  logic                req_valid;
  bin_req_t            req;
  logic                sum_valid;
  blk_sum_t            blk_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_pixels_q <= LINE_RESET;
      factor_q      <= FACTOR_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_LINE_PIXELS: line_pixels_q <= cfg_data_i;
        CFG_FACTOR:      factor_q      <= cfg_data_i[FACTOR_W-1:0];
        default:         line_pixels_q <= line_pixels_q;
      endcase
    end
  end

  assign advance    = !out_valid_o || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  bavg_locate u_locate (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .advance_i     (advance),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .line_pixels_i (line_pixels_q),
    .factor_i      (factor_q),
    .rd_addr_o     (rd_addr),
    .req_valid_o   (req_valid),
    .req_o         (req)
  );

  bavg_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .rd_addr_i   (rd_addr),
    .req_valid_i (req_valid),
    .req_i       (req),
    .sum_valid_o (sum_valid),
    .sum_o       (blk_sum)
  );

  bavg_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .sum_valid_i (sum_valid),
    .sum_i       (blk_sum),
    .out_valid_o (out_valid_o),
    .average_o   (average_o),
    .line_end_o  (line_end_o)
  );

endmodule

`default_nettype wire
